// ===== sv/vna_pkg.sv =====
`timescale 1ns / 1ps

package vna_pkg;

	// width of the working vector: cross products and accumulator reads
	localparam int VEC_W = 35;

	localparam logic [1:0] OPC_WRITE = 2'd0;
	localparam logic [1:0] OPC_TRI   = 2'd1;
	localparam logic [1:0] OPC_READ  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_RANGE = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_CLEAR,
		OP_WRITE,
		OP_POS_RD,
		OP_POS_CAP,
		OP_MUL,
		OP_CR,
		OP_MAG,
		OP_SHIFT,
		OP_SQ,
		OP_SEED,
		OP_Y2,
		OP_H,
		OP_Y,
		OP_NOUT,
		OP_ACC_RD,
		OP_ACC_WR,
		OP_ACC_LOAD,
		OP_RESULT
	} dp_op_t;

	typedef enum logic [2:0] {
		MS_CROSS,
		MS_SQ,
		MS_YY,
		MS_SY,
		MS_YH,
		MS_OUT
	} mul_sel_t;

	typedef struct packed {
		dp_op_t   op;
		mul_sel_t mul;
		logic [2:0] idx;
		status_t  status;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] opc;
		logic vi_ok;
		logic tri_ok;
		logic vec_zero;
		logic big_hi;
		logic big_lo;
		logic clr_last;
		logic sat;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== sv/vna_ctrl.sv =====
`timescale 1ns / 1ps

module vna_ctrl import vna_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [25:0] {
		S_CLEAR  = 26'd1,
		S_IDLE   = 26'd2,
		S_DECODE = 26'd4,
		S_WRITE  = 26'd8,
		S_PRD    = 26'd16,
		S_PCAP   = 26'd32,
		S_CMUL   = 26'd64,
		S_CACC   = 26'd128,
		S_MAG    = 26'd256,
		S_SHIFT  = 26'd512,
		S_SQMUL  = 26'd1024,
		S_SQACC  = 26'd2048,
		S_SEED   = 26'd4096,
		S_YYMUL  = 26'd8192,
		S_YYACC  = 26'd16384,
		S_SYMUL  = 26'd32768,
		S_SYACC  = 26'd65536,
		S_YHMUL  = 26'd131072,
		S_YHACC  = 26'd262144,
		S_OMUL   = 26'd524288,
		S_OACC   = 26'd1048576,
		S_ARD    = 26'd2097152,
		S_AWR    = 26'd4194304,
		S_LDRD   = 26'd8388608,
		S_LDCAP  = 26'd16777216,
		S_FIN    = 26'd33554432
	} state_t;

	localparam logic [2:0] NEWTON_LAST = 3'd4;

	state_t     state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic [2:0] it_q, it_d;
	status_t    st_q, st_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		it_d       = it_q;
		st_d       = st_q;
		cmd.op     = OP_NOP;
		cmd.mul    = MS_CROSS;
		cmd.idx    = cnt_q;
		cmd.status = st_q;
		case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					st_d    = ST_OK;
					cnt_d   = 3'd0;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.opc)
					OPC_WRITE: begin
						if (stat.vi_ok) state_d = S_WRITE;
						else begin
							st_d    = ST_RANGE;
							state_d = S_FIN;
						end
					end
					OPC_TRI: begin
						if (stat.tri_ok) state_d = S_PRD;
						else begin
							st_d    = ST_RANGE;
							state_d = S_FIN;
						end
					end
					OPC_READ: begin
						if (stat.vi_ok) state_d = S_LDRD;
						else begin
							st_d    = ST_RANGE;
							state_d = S_FIN;
						end
					end
					default: begin
						st_d    = ST_RANGE;
						state_d = S_FIN;
					end
				endcase
			end
			S_WRITE: begin
				cmd.op  = OP_WRITE;
				state_d = S_FIN;
			end
			S_PRD: begin
				cmd.op  = OP_POS_RD;
				state_d = S_PCAP;
			end
			S_PCAP: begin
				cmd.op = OP_POS_CAP;
				if (cnt_q == 3'd2) begin
					cnt_d   = 3'd0;
					state_d = S_CMUL;
				end else begin
					cnt_d   = cnt_q + 3'd1;
					state_d = S_PRD;
				end
			end
			S_CMUL: begin
				cmd.op  = OP_MUL;
				cmd.mul = MS_CROSS;
				state_d = S_CACC;
			end
			S_CACC: begin
				cmd.op = OP_CR;
				if (cnt_q == 3'd5) begin
					cnt_d   = 3'd0;
					state_d = S_MAG;
				end else begin
					cnt_d   = cnt_q + 3'd1;
					state_d = S_CMUL;
				end
			end
			S_MAG: begin
				if (stat.vec_zero) begin
					st_d    = ST_ZERO;
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_MAG;
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (stat.big_hi || stat.big_lo) cmd.op = OP_SHIFT;
				else begin
					cnt_d   = 3'd0;
					state_d = S_SQMUL;
				end
			end
			S_SQMUL: begin
				cmd.op  = OP_MUL;
				cmd.mul = MS_SQ;
				state_d = S_SQACC;
			end
			S_SQACC: begin
				cmd.op = OP_SQ;
				if (cnt_q == 3'd2) begin
					cnt_d   = 3'd0;
					state_d = S_SEED;
				end else begin
					cnt_d   = cnt_q + 3'd1;
					state_d = S_SQMUL;
				end
			end
			S_SEED: begin
				cmd.op  = OP_SEED;
				it_d    = 3'd0;
				state_d = S_YYMUL;
			end
			S_YYMUL: begin
				cmd.op  = OP_MUL;
				cmd.mul = MS_YY;
				state_d = S_YYACC;
			end
			S_YYACC: begin
				cmd.op  = OP_Y2;
				state_d = S_SYMUL;
			end
			S_SYMUL: begin
				cmd.op  = OP_MUL;
				cmd.mul = MS_SY;
				state_d = S_SYACC;
			end
			S_SYACC: begin
				cmd.op  = OP_H;
				state_d = S_YHMUL;
			end
			S_YHMUL: begin
				cmd.op  = OP_MUL;
				cmd.mul = MS_YH;
				state_d = S_YHACC;
			end
			S_YHACC: begin
				cmd.op = OP_Y;
				if (it_q == NEWTON_LAST) begin
					cnt_d   = 3'd0;
					state_d = S_OMUL;
				end else begin
					it_d    = it_q + 3'd1;
					state_d = S_YYMUL;
				end
			end
			S_OMUL: begin
				cmd.op  = OP_MUL;
				cmd.mul = MS_OUT;
				state_d = S_OACC;
			end
			S_OACC: begin
				cmd.op = OP_NOUT;
				if (cnt_q == 3'd2) begin
					cnt_d   = 3'd0;
					state_d = (stat.opc == OPC_TRI) ? S_ARD : S_FIN;
				end else begin
					cnt_d   = cnt_q + 3'd1;
					state_d = S_OMUL;
				end
			end
			S_ARD: begin
				cmd.op  = OP_ACC_RD;
				state_d = S_AWR;
			end
			S_AWR: begin
				cmd.op = OP_ACC_WR;
				if (cnt_q == 3'd2) begin
					cnt_d   = 3'd0;
					state_d = S_FIN;
				end else begin
					cnt_d   = cnt_q + 3'd1;
					state_d = S_ARD;
				end
			end
			S_LDRD: begin
				cmd.op  = OP_ACC_RD;
				cmd.idx = 3'd3;
				state_d = S_LDCAP;
			end
			S_LDCAP: begin
				cmd.op  = OP_ACC_LOAD;
				state_d = S_MAG;
			end
			S_FIN: begin
				cmd.status = (st_q == ST_OK && stat.sat) ? ST_SAT : st_q;
				if (stat.out_free) begin
					cmd.op  = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= 3'd0;
			it_q    <= 3'd0;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			it_q    <= it_d;
			st_q    <= st_d;
		end
	end

endmodule

// ===== sv/vna_datapath.sv =====
`timescale 1ns / 1ps

module vna_datapath import vna_pkg::*; #(
	parameter int VERTEX_DEPTH = 256,
	parameter int ACCUM_WIDTH  = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [1:0]         operation,
	input  logic [7:0]         vertex_index,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [7:0]         corner_a,
	input  logic [7:0]         corner_b,
	input  logic [7:0]         corner_c,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [1:0]         status
);

	localparam int ADDR_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int ACC_W3 = 3 * ACCUM_WIDTH;
	localparam logic signed [ACCUM_WIDTH-1:0] ACC_HI = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
	localparam logic signed [ACCUM_WIDTH-1:0] ACC_LO = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
	localparam logic [31:0] SEED_0    = 32'h6800_0000; // 1.625
	localparam logic [31:0] SEED_1    = 32'h4A00_0000; // 1.15625
	localparam logic [31:0] SEED_2    = 32'h3400_0000; // 0.8125
	localparam logic [31:0] SEED_3    = 32'h2800_0000; // 0.625
	localparam logic [31:0] HALF_Q30  = 32'h2000_0000;
	localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
	localparam logic [31:0] TWO_Q30   = 32'h8000_0000;
	localparam logic [33:0] THREE_Q30 = 34'h0_C000_0000;
	localparam logic [48:0] ROUND_31  = 49'h0_0000_4000_0000;
	localparam logic [17:0] UNIT_MAX  = 18'd16384;

	// captured item
	logic [1:0]  opc_q;
	logic [7:0]  vi_q, ca_q, cb_q, cc_q;
	logic [47:0] wpos_q;

	logic [47:0] pos_mem [VERTEX_DEPTH];
	logic [ACC_W3-1:0] acc_mem [VERTEX_DEPTH];
	logic [47:0] pos_rd_q;
	logic [ACC_W3-1:0] acc_rd_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic [47:0] pp_q [3];
	logic signed [VEC_W-1:0] v_q [3];
	logic [VEC_W-1:0] m_q [3];
	logic [2:0]  sgn_q;
	logic [31:0] s_q, y_q, h_q;
	logic [32:0] y2_q;
	logic signed [67:0] prod_q;
	logic signed [15:0] n_q [3];
	logic        sat_q;

	logic               out_valid_q;
	logic signed [15:0] nx_q, ny_q, nz_q;
	logic [1:0]         status_q;

	// combinational
	logic [7:0]        sel_ix;
	logic [ADDR_W-1:0] sel_addr, vi_addr;
	logic signed [16:0] e1 [3];
	logic signed [16:0] e2 [3];
	logic signed [33:0] mul_a, mul_b;
	logic [VEC_W-1:0]   m_sel, m_or;
	logic               sgn_sel;
	logic [48:0]        rnd;
	logic [17:0]        rmag;
	logic [14:0]        rcap;
	logic signed [15:0] n_new;
	logic [33:0]        p_hi;
	logic signed [ACCUM_WIDTH-1:0] acc_a [3];
	logic signed [ACCUM_WIDTH-1:0] acc_new [3];
	logic signed [ACCUM_WIDTH:0]   acc_sum [3];
	logic [2:0] acc_clip, acc_edge;
	logic        pos_we, acc_we;
	logic [ADDR_W-1:0] pos_wa, acc_wa;
	logic [47:0] pos_wd;
	logic [ACC_W3-1:0] acc_wd;

	always_comb begin
		case (cmd.idx[1:0])
			2'd0:    sel_ix = ca_q;
			2'd1:    sel_ix = cb_q;
			2'd2:    sel_ix = cc_q;
			default: sel_ix = vi_q;
		endcase
		case (cmd.idx[1:0])
			2'd0:    begin m_sel = m_q[0]; sgn_sel = sgn_q[0]; end
			2'd1:    begin m_sel = m_q[1]; sgn_sel = sgn_q[1]; end
			default: begin m_sel = m_q[2]; sgn_sel = sgn_q[2]; end
		endcase
	end

	assign sel_addr = ADDR_W'(sel_ix);
	assign vi_addr  = ADDR_W'(vi_q);

	// edges b - a and c - a
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			e1[k] = 17'(signed'(pp_q[1][47-16*k -: 16])) - 17'(signed'(pp_q[0][47-16*k -: 16]));
			e2[k] = 17'(signed'(pp_q[2][47-16*k -: 16])) - 17'(signed'(pp_q[0][47-16*k -: 16]));
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul)
			MS_CROSS: begin
				case (cmd.idx)
					3'd0:    begin mul_a = 34'(e1[1]); mul_b = 34'(e2[2]); end
					3'd1:    begin mul_a = 34'(e1[2]); mul_b = 34'(e2[1]); end
					3'd2:    begin mul_a = 34'(e1[2]); mul_b = 34'(e2[0]); end
					3'd3:    begin mul_a = 34'(e1[0]); mul_b = 34'(e2[2]); end
					3'd4:    begin mul_a = 34'(e1[0]); mul_b = 34'(e2[1]); end
					default: begin mul_a = 34'(e1[1]); mul_b = 34'(e2[0]); end
				endcase
			end
			MS_SQ: begin
				mul_a = {19'd0, m_sel[14:0]};
				mul_b = {19'd0, m_sel[14:0]};
			end
			MS_YY: begin
				mul_a = {2'b00, y_q};
				mul_b = {2'b00, y_q};
			end
			MS_SY: begin
				mul_a = {2'b00, s_q};
				mul_b = {1'b0, y2_q};
			end
			MS_YH: begin
				mul_a = {2'b00, y_q};
				mul_b = {2'b00, h_q};
			end
			MS_OUT: begin
				mul_a = {19'd0, m_sel[14:0]};
				mul_b = {2'b00, y_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// rounding of the output component
	always_comb begin
		rnd   = {1'b0, prod_q[47:0]} + ROUND_31;
		rmag  = rnd[48:31];
		rcap  = (rmag > UNIT_MAX) ? UNIT_MAX[14:0] : rmag[14:0];
		n_new = sgn_sel ? -$signed({1'b0, rcap}) : $signed({1'b0, rcap});
		p_hi  = prod_q[63:30];
	end

	// saturating accumulate
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc_a[k]    = acc_rd_q[ACC_W3-1-k*ACCUM_WIDTH -: ACCUM_WIDTH];
			acc_sum[k]  = (ACCUM_WIDTH+1)'(acc_a[k]) + (ACCUM_WIDTH+1)'(n_q[k]);
			acc_clip[k] = 1'b0;
			acc_new[k]  = acc_sum[k][ACCUM_WIDTH-1:0];
			if (acc_sum[k] > (ACCUM_WIDTH+1)'(ACC_HI)) begin
				acc_new[k]  = ACC_HI;
				acc_clip[k] = 1'b1;
			end else if (acc_sum[k] < (ACCUM_WIDTH+1)'(ACC_LO)) begin
				acc_new[k]  = ACC_LO;
				acc_clip[k] = 1'b1;
			end
			acc_edge[k] = (acc_a[k] == ACC_HI) || (acc_a[k] == ACC_LO);
		end
	end

	always_comb begin
		pos_we = 1'b0;
		pos_wa = clr_addr_q;
		pos_wd = '0;
		acc_we = 1'b0;
		acc_wa = clr_addr_q;
		acc_wd = '0;
		case (cmd.op)
			OP_CLEAR: begin
				pos_we = 1'b1;
				acc_we = 1'b1;
			end
			OP_WRITE: begin
				pos_we = 1'b1;
				pos_wa = vi_addr;
				pos_wd = wpos_q;
				acc_we = 1'b1;
				acc_wa = vi_addr;
			end
			OP_ACC_WR: begin
				acc_we = 1'b1;
				acc_wa = sel_addr;
				acc_wd = {acc_new[0], acc_new[1], acc_new[2]};
			end
			default: begin
				pos_we = 1'b0;
				acc_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		if (cmd.op == OP_POS_RD) pos_rd_q <= pos_mem[sel_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_wa] <= acc_wd;
		if (cmd.op == OP_ACC_RD) acc_rd_q <= acc_mem[sel_addr];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				opc_q  <= operation;
				vi_q   <= vertex_index;
				ca_q   <= corner_a;
				cb_q   <= corner_b;
				cc_q   <= corner_c;
				wpos_q <= {pos_x, pos_y, pos_z};
				sat_q  <= 1'b0;
				for (int k = 0; k < 3; k++) n_q[k] <= '0;
			end
			OP_POS_CAP: pp_q[cmd.idx[1:0]] <= pos_rd_q;
			OP_MUL:     prod_q <= mul_a * mul_b;
			OP_CR: begin
				if (!cmd.idx[0]) v_q[cmd.idx[2:1]] <= VEC_W'(prod_q);
				else v_q[cmd.idx[2:1]] <= v_q[cmd.idx[2:1]] - VEC_W'(prod_q);
			end
			OP_MAG: begin
				for (int k = 0; k < 3; k++) begin
					sgn_q[k] <= v_q[k][VEC_W-1];
					m_q[k]   <= v_q[k][VEC_W-1] ? VEC_W'(-v_q[k]) : VEC_W'(v_q[k]);
				end
				s_q <= '0;
			end
			OP_SHIFT: begin
				for (int k = 0; k < 3; k++)
					m_q[k] <= stat.big_hi ? (m_q[k] >> 1) : (m_q[k] << 1);
			end
			OP_SQ: s_q <= s_q + prod_q[31:0];
			OP_SEED: begin
				if (s_q < HALF_Q30)     y_q <= SEED_0;
				else if (s_q < ONE_Q30) y_q <= SEED_1;
				else if (s_q < TWO_Q30) y_q <= SEED_2;
				else                    y_q <= SEED_3;
			end
			OP_Y2: y2_q <= prod_q[62:30];
			OP_H:  h_q <= (p_hi >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - p_hi);
			OP_Y:  y_q <= prod_q[62:31];
			OP_NOUT: n_q[cmd.idx[1:0]] <= n_new;
			OP_ACC_WR: sat_q <= sat_q | (|acc_clip);
			OP_ACC_LOAD: begin
				for (int k = 0; k < 3; k++) v_q[k] <= VEC_W'(acc_a[k]);
				sat_q <= |acc_edge;
			end
			OP_RESULT: begin
				nx_q     <= n_q[0];
				ny_q     <= n_q[1];
				nz_q     <= n_q[2];
				status_q <= cmd.status;
			end
			default: begin
				sat_q <= sat_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			clr_addr_q  <= '0;
		end else begin
			if (cmd.op == OP_RESULT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (cmd.op == OP_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign m_or = m_q[0] | m_q[1] | m_q[2];

	always_comb begin
		stat.opc      = opc_q;
		stat.vi_ok    = {24'd0, vi_q} < 32'(VERTEX_DEPTH);
		stat.tri_ok   = ({24'd0, ca_q} < 32'(VERTEX_DEPTH)) &&
		                ({24'd0, cb_q} < 32'(VERTEX_DEPTH)) &&
		                ({24'd0, cc_q} < 32'(VERTEX_DEPTH));
		stat.vec_zero = (v_q[0] == '0) && (v_q[1] == '0) && (v_q[2] == '0);
		stat.big_hi   = |m_or[VEC_W-1:15];
		stat.big_lo   = ~|m_or[VEC_W-1:14];
		stat.clr_last = (clr_addr_q == ADDR_W'(VERTEX_DEPTH - 1));
		stat.sat      = sat_q;
		stat.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign normal_x  = nx_q;
	assign normal_y  = ny_q;
	assign normal_z  = nz_q;
	assign status    = status_q;

endmodule

// ===== sv/vertex_normal_accumulator.sv =====
`timescale 1ns / 1ps

// Smooth vertex normals by face-normal averaging. Every accepted item gives
// exactly one result item. A write (operation 0) stores a Q8.8 position and
// clears that vertex's accumulator; a triangle (operation 1) forms the cross
// product of (b - a) and (c - a), normalizes it to a Q1.14 unit face normal,
// returns it and adds it with saturation to all three corner accumulators; a
// read (operation 2) returns the normalized accumulator of one vertex. Status:
// 0 ok, 1 zero-length vector, 2 index out of range or unknown operation,
// 3 accumulator saturated. Items are handled one at a time: a new item is
// taken only after the last one has left for the output register. The time
// per item is set by the single shared 34x34 multiplier (six cross-product
// terms, three squares, fifteen Newton products and three output scalings,
// each a multiply step and an accumulate step), by the one-bit-per-cycle
// prescale shifter (up to 19 steps for a triangle, up to 14 for a read) and
// by the single read port of the vertex memories (a read step and a capture
// step per corner). After reset the block sweeps both memories to zero, one
// entry per cycle, with in_stall held high. A finished result waits in the
// output register while the next item is taken in.

module vertex_normal_accumulator import vna_pkg::*; #(
	parameter int VERTEX_DEPTH = 256,
	parameter int ACCUM_WIDTH  = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [7:0]         vertex_index,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [7:0]         corner_a,
	input  logic [7:0]         corner_b,
	input  logic [7:0]         corner_c,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [1:0]         status
);

	// controller -> datapath commands, datapath -> controller status
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: one item at a time, steps the shared multiplier
	vna_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// memories, multiplier, Newton registers, accumulators, result register
	vna_datapath #(
		.VERTEX_DEPTH (VERTEX_DEPTH),
		.ACCUM_WIDTH  (ACCUM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operation    (operation),
		.vertex_index (vertex_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.status       (status)
	);

endmodule

// ===== sv/vna_checker.sv =====
`timescale 1ns / 1ps

module vna_checker import vna_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic [1:0]         status
);

	// zero-length and out-of-range results carry no normal
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ZERO || status == ST_RANGE) |->
			normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0)
		else $error("failed item carries a nonzero normal");

	// every component stays within the unit range
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			normal_x >= -16'sd16384 && normal_x <= 16'sd16384 &&
			normal_y >= -16'sd16384 && normal_y <= 16'sd16384 &&
			normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
		else $error("normal component out of Q1.14 unit range");

	// a saturated result always carries a nonzero normal
	a_sat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SAT |->
			normal_x != 16'sd0 || normal_y != 16'sd0 || normal_z != 16'sd0)
		else $error("saturated item with zero normal");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(normal_x))
		else $error("stalled result changed");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);
